// File: sv/ashp_pkg.sv
// Package for the wrapper header parser: field widths, header constants,
// phase and status codes, and the result word type. No dependencies.
`timescale 1ns / 1ps

package ashp_pkg;

  localparam int unsigned FSIZE_W = 40;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned END_W   = 33;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned TEND_W  = 20;

  localparam logic [WORD_W-1:0] MAGIC_ONE   = 32'h0005_1600;
  localparam logic [WORD_W-1:0] MAGIC_TWO   = 32'h0005_1607;
  localparam logic [WORD_W-1:0] VERSION_ONE = 32'h0001_0000;
  localparam logic [WORD_W-1:0] VERSION_TWO = 32'h0002_0000;

  localparam logic [TEND_W-1:0] HDR_BYTES = 20'd26;

  // Position of the first byte, and byte positions at which a field is complete.
  localparam logic [POS_W-1:0] POS_FIRST       = 5'd0;
  localparam logic [POS_W-1:0] POS_MAGIC_LAST  = 5'd3;
  localparam logic [POS_W-1:0] POS_VER_LAST    = 5'd7;
  localparam logic [POS_W-1:0] POS_COUNT_LAST  = 5'd25;
  localparam logic [POS_W-1:0] POS_ID_LAST     = 5'd3;
  localparam logic [POS_W-1:0] POS_OFFSET_LAST = 5'd7;
  localparam logic [POS_W-1:0] POS_DESC_LAST   = 5'd11;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DESC,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_ZERO_COUNT  = 3'd3,
    ST_TABLE_BIG   = 3'd4,
    ST_OUT_RANGE   = 3'd5,
    ST_TOO_SHORT   = 3'd6
  } status_e;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] length;
    logic [CNT_W-1:0]  index;
    logic [END_W-1:0]  span_end;
    logic              last;
  } result_t;

endpackage

// File: sv/ashp_parser.sv
// Header and descriptor parser: parse state registers and the checks made
// on each byte word. Depends on ashp_pkg.
`timescale 1ns / 1ps

module ashp_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  input  logic [ashp_pkg::FSIZE_W-1:0] file_size_i,
  output ashp_pkg::result_t       res_o
);
  import ashp_pkg::*;

  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [WORD_W-1:0]   shift_q, shift_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    dn_q, dn_d;
  logic [WORD_W-1:0]   held_id_q, held_id_d;
  logic [WORD_W-1:0]   held_off_q, held_off_d;
  logic [END_W-1:0]    far_q, far_d;

  // A first_byte marker restarts the parse on the same byte.
  phase_e              eff_phase;
  logic [POS_W-1:0]    eff_pos;
  logic [WORD_W-1:0]   eff_shift;
  logic [CNT_W-1:0]    eff_count;
  logic [CNT_W-1:0]    eff_dn;
  logic [WORD_W-1:0]   eff_held_id;
  logic [WORD_W-1:0]   eff_held_off;
  logic [END_W-1:0]    eff_far;

  assign eff_phase    = first_byte_i ? PH_HEADER : phase_q;
  assign eff_pos      = first_byte_i ? '0 : pos_q;
  assign eff_shift    = first_byte_i ? '0 : shift_q;
  assign eff_count    = first_byte_i ? '0 : count_q;
  assign eff_dn       = first_byte_i ? '0 : dn_q;
  assign eff_held_id  = first_byte_i ? '0 : held_id_q;
  assign eff_held_off = first_byte_i ? '0 : held_off_q;
  assign eff_far      = first_byte_i ? '0 : far_q;

  logic              in_hdr, in_desc;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  cnt;
  logic [TEND_W-1:0] table_end;
  logic [END_W-1:0]  ent_end;
  logic [END_W-1:0]  new_far;
  logic              short_err, magic_err, ver_err, zero_err, table_err, range_err;
  logic              hdr_end, desc_end, hdr_fail, is_final;

  assign in_hdr  = (eff_phase == PH_HEADER);
  assign in_desc = (eff_phase == PH_DESC);
  assign word    = {eff_shift[WORD_W-9:0], data_byte_i};

  // Header checks.
  assign short_err = in_hdr && (eff_pos == POS_FIRST) &&
                     (file_size_i < FSIZE_W'(HDR_BYTES));
  assign magic_err = in_hdr && (eff_pos == POS_MAGIC_LAST) &&
                     (word != MAGIC_ONE) && (word != MAGIC_TWO);
  assign ver_err   = in_hdr && (eff_pos == POS_VER_LAST) &&
                     (word != VERSION_ONE) && (word != VERSION_TWO);
  assign hdr_end   = in_hdr && (eff_pos >= POS_COUNT_LAST);
  assign cnt       = word[CNT_W-1:0];
  // Table end is 26 plus 12 times the count, built from two shifts.
  assign table_end = HDR_BYTES + {1'b0, cnt, 3'b000} + {2'b00, cnt, 2'b00};
  assign zero_err  = hdr_end && (cnt == '0);
  assign table_err = hdr_end && (cnt != '0) &&
                     (FSIZE_W'(table_end) > file_size_i);
  assign hdr_fail  = short_err || magic_err || ver_err || zero_err || table_err;

  // Descriptor checks.
  assign desc_end  = in_desc && (eff_pos >= POS_DESC_LAST);
  assign ent_end   = {1'b0, eff_held_off} + {1'b0, word};
  assign range_err = desc_end && (FSIZE_W'(ent_end) > file_size_i);
  assign new_far   = (ent_end > eff_far) ? ent_end : eff_far;
  assign is_final  = ({1'b0, eff_dn} + 17'd1) >= {1'b0, eff_count};

  // Next parse state.
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    shift_d    = shift_q;
    count_d    = count_q;
    dn_d       = dn_q;
    held_id_d  = held_id_q;
    held_off_d = held_off_q;
    far_d      = far_q;
    if (step_i) begin
      phase_d    = eff_phase;
      pos_d      = eff_pos;
      shift_d    = eff_shift;
      count_d    = eff_count;
      dn_d       = eff_dn;
      held_id_d  = eff_held_id;
      held_off_d = eff_held_off;
      far_d      = eff_far;
      if (in_hdr || in_desc) begin
        shift_d = word;
      end
      priority if (hdr_fail || range_err) begin
        phase_d = PH_ERROR;
      end else if (hdr_end) begin
        count_d = cnt;
        dn_d    = '0;
        far_d   = END_W'(table_end);
        phase_d = PH_DESC;
        pos_d   = '0;
      end else if (in_hdr) begin
        pos_d = eff_pos + 5'd1;
      end else if (desc_end) begin
        far_d = new_far;
        pos_d = '0;
        if (is_final) begin
          phase_d = PH_DONE;
        end else begin
          dn_d = eff_dn + 16'd1;
        end
      end else if (in_desc) begin
        if (eff_pos == POS_ID_LAST) begin
          held_id_d = word;
        end else if (eff_pos == POS_OFFSET_LAST) begin
          held_off_d = word;
        end
        pos_d = eff_pos + 5'd1;
      end else begin
        phase_d = eff_phase;
      end
    end
  end

  // Result word for this byte.
  always_comb begin
    res_o          = '0;
    res_o.status   = ST_OK;
    res_o.span_end = eff_far;
    res_o.valid    = step_i && (hdr_fail || desc_end);
    priority if (short_err) begin
      res_o.status = ST_TOO_SHORT;
      res_o.last   = 1'b1;
    end else if (magic_err) begin
      res_o.status = ST_BAD_MAGIC;
      res_o.last   = 1'b1;
    end else if (ver_err) begin
      res_o.status = ST_BAD_VERSION;
      res_o.last   = 1'b1;
    end else if (zero_err) begin
      res_o.status = ST_ZERO_COUNT;
      res_o.last   = 1'b1;
    end else if (table_err) begin
      res_o.status = ST_TABLE_BIG;
      res_o.last   = 1'b1;
    end else if (desc_end) begin
      res_o.status = range_err ? ST_OUT_RANGE : ST_OK;
      res_o.id     = eff_held_id;
      res_o.offset = eff_held_off;
      res_o.length = word;
      res_o.index  = eff_dn;
      res_o.last   = range_err || is_final;
      if (!range_err) begin
        res_o.span_end = new_far;
      end
    end else begin
      res_o.last = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      shift_q    <= '0;
      count_q    <= '0;
      dn_q       <= '0;
      held_id_q  <= '0;
      held_off_q <= '0;
      far_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      shift_q    <= shift_d;
      count_q    <= count_d;
      dn_q       <= dn_d;
      held_id_q  <= held_id_d;
      held_off_q <= held_off_d;
      far_q      <= far_d;
    end
  end

  // Every error result closes the wrapper.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != ST_OK) |-> res_o.last)
    else $error("error result without last");

  // A finished or failed parse stays silent until a new marker.
  a_quiet_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_DONE) || (phase_q == PH_ERROR)) && !first_byte_i |-> !res_o.valid)
    else $error("result after end of parse");

  // A last result always moves the parse out of the active phases.
  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last |=> (phase_q == PH_DONE) || (phase_q == PH_ERROR))
    else $error("parse still active after last result");

  // The byte position never runs past a header or a descriptor.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_HEADER) && (pos_q <= POS_COUNT_LAST)) ||
    ((phase_q == PH_DESC) && (pos_q <= POS_DESC_LAST)) ||
    (phase_q == PH_DONE) || (phase_q == PH_ERROR))
    else $error("byte position out of range");

endmodule

// File: sv/ashp_result_reg.sv
// Output register for result words, with its valid flag and the advance
// signal for the stage in front. Depends on ashp_pkg.
`timescale 1ns / 1ps

module ashp_result_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ashp_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              advance_o,
  output logic              out_valid_o,
  output ashp_pkg::result_t res_o
);
  import ashp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  // The register can take a new word when empty or when its word leaves.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (advance_o) begin
      valid_d = res_i.valid;
      if (res_i.valid) begin
        data_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

  // A result offered while the register can advance is shown next cycle.
  a_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && res_i.valid |=> out_valid_o)
    else $error("result word lost");

  // Without a new word, a taken result empties the register.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_ready_i && !res_i.valid |=> !out_valid_o)
    else $error("result word repeated");

  // A result offered while stalled must not exist: the front stage holds.
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |-> !res_i.valid)
    else $error("result offered during stall");

endmodule

// File: sv/applesingle_header_parser_core.sv
// Wrapper header parser top level. A byte is held in the input register and
// checked by the parser logic; a result it yields is stored in the result
// register. Throughput: one byte per cycle; in_ready_o falls only when both
// the input register and the result register are full and out_ready_i is low.
// Reset (rst_ni, asynchronous, active low) clears file_size to zero, empties
// both registers and restarts parsing at header byte 0.
`timescale 1ns / 1ps

module applesingle_header_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ashp_pkg::FSIZE_W-1:0] cfg_file_size_i,
  // Input byte channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         first_byte_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic [ashp_pkg::WORD_W-1:0]  entry_id_o,
  output logic [ashp_pkg::WORD_W-1:0]  entry_offset_o,
  output logic [ashp_pkg::WORD_W-1:0]  entry_length_o,
  output logic [ashp_pkg::CNT_W-1:0]   entry_index_o,
  output logic [ashp_pkg::END_W-1:0]   span_end_o,
  output logic                         last_o
);
  import ashp_pkg::*;

  logic [FSIZE_W-1:0] file_size_q;
  logic               in_valid_q, in_valid_d;
  logic [7:0]         byte_q;
  logic               first_q;
  logic               advance;
  logic               step;
  result_t            res_comb;
  result_t            res_out;

  // File size register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      file_size_q <= cfg_file_size_i;
    end
  end

  // Input register: holds one word while the result side stalls.
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
    end
  end

  ashp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (byte_q),
    .first_byte_i (first_q),
    .file_size_i  (file_size_q),
    .res_o        (res_comb)
  );

  ashp_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res_comb),
    .out_ready_i (out_ready_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  // Result fields onto their ports.
  assign status_o       = res_out.status;
  assign entry_id_o     = res_out.id;
  assign entry_offset_o = res_out.offset;
  assign entry_length_o = res_out.length;
  assign entry_index_o  = res_out.index;
  assign span_end_o     = res_out.span_end;
  assign last_o         = res_out.last;

  // Input backpressure only when both registers are occupied and stalled.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without cause");

  // A held word is processed as soon as the result side frees up.
  a_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q) && $stable(first_q))
    else $error("held input word changed");

  // A parser result always comes from a processed word.
  a_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_comb.valid |-> step)
    else $error("result without a processed word");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the wrapper header parser core.
// Depends on ashp_pkg and applesingle_header_parser_core; a scoreboard
// class predicts every parse result from the accepted bytes.
`timescale 1ns / 1ps

module testbench;
  import ashp_pkg::*;

  localparam logic [TEND_W-1:0] DESC_BYTES = 20'd12;
  localparam int unsigned       MAX_DESCS  = 6;
  localparam int unsigned       PHASE_BYTES = 106;
  localparam longint unsigned   LIMIT_NS   = 64'd8_000_000;

  // One expected result word of the parser.
  typedef struct {
    status_e           st;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] off;
    logic [WORD_W-1:0] len;
    logic [CNT_W-1:0]  idx;
    logic [END_W-1:0]  aend;
    logic              last_flag;
  } entry_t;

  // Tracks the parser state from accepted bytes and matches its results.
  class wrapper_tracker;
    logic [FSIZE_W-1:0] size_reg;
    phase_e             ph;
    logic [POS_W-1:0]   pos;
    logic [WORD_W-1:0]  shreg;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   desc_num;
    logic [WORD_W-1:0]  id_hold;
    logic [WORD_W-1:0]  off_hold;
    logic [33:0]        far_end;
    entry_t             pending_entries[$];
    int unsigned        mismatches;
    int unsigned        entries_seen;
    int unsigned        errors_seen;

    function new();
      size_reg     = '0;
      mismatches   = 0;
      entries_seen = 0;
      errors_seen  = 0;
      restart();
    endfunction

    function void restart();
      ph       = PH_HEADER;
      pos      = '0;
      shreg    = '0;
      count    = '0;
      desc_num = '0;
      id_hold  = '0;
      off_hold = '0;
      far_end  = '0;
    endfunction

    function void set_size(logic [FSIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned pending();
      return pending_entries.size();
    endfunction

    function void push(status_e st, logic [WORD_W-1:0] id, logic [WORD_W-1:0] off,
                       logic [WORD_W-1:0] len, logic [CNT_W-1:0] idx, logic lst);
      entry_t e;
      e.st        = st;
      e.id        = id;
      e.off       = off;
      e.len       = len;
      e.idx       = idx;
      e.aend      = far_end[END_W-1:0];
      e.last_flag = lst;
      pending_entries.push_back(e);
    endfunction

    // Header errors carry zero descriptor fields and end the wrapper.
    function void header_error(status_e st);
      ph = PH_ERROR;
      push(st, '0, '0, '0, '0, 1'b1);
    endfunction

    // Advances the parse by one accepted byte.
    function void take_byte(logic [7:0] b, logic first);
      logic [CNT_W-1:0]  cnt;
      logic [33:0]       tbl_end;
      logic [33:0]       ent_end;
      logic [WORD_W-1:0] len;
      logic              is_final;
      if (first) restart();
      if (ph != PH_HEADER && ph != PH_DESC) return;
      shreg = {shreg[23:0], b};

      if (ph == PH_HEADER) begin
        if (pos == POS_FIRST && size_reg < HDR_BYTES) begin
          header_error(ST_TOO_SHORT);
          return;
        end
        if (pos == POS_MAGIC_LAST && shreg != MAGIC_ONE && shreg != MAGIC_TWO) begin
          header_error(ST_BAD_MAGIC);
          return;
        end
        if (pos == POS_VER_LAST && shreg != VERSION_ONE && shreg != VERSION_TWO) begin
          header_error(ST_BAD_VERSION);
          return;
        end
        if (pos >= POS_COUNT_LAST) begin
          cnt     = shreg[CNT_W-1:0];
          tbl_end = HDR_BYTES + DESC_BYTES * cnt;
          if (cnt == '0) begin
            header_error(ST_ZERO_COUNT);
            return;
          end
          if (tbl_end > size_reg) begin
            header_error(ST_TABLE_BIG);
            return;
          end
          count    = cnt;
          desc_num = '0;
          far_end  = tbl_end;
          ph       = PH_DESC;
          pos      = '0;
          return;
        end
        pos = pos + 1'b1;
        return;
      end

      // Descriptor table: id, offset, then length completes the entry.
      if (pos == POS_ID_LAST) id_hold = shreg;
      else if (pos == POS_OFFSET_LAST) off_hold = shreg;
      if (pos >= POS_DESC_LAST) begin
        len     = shreg;
        ent_end = {2'b00, off_hold} + {2'b00, len};
        if (ent_end > size_reg) begin
          ph = PH_ERROR;
          push(ST_OUT_RANGE, id_hold, off_hold, len, desc_num, 1'b1);
          return;
        end
        if (ent_end > far_end) far_end = ent_end;
        is_final = ({1'b0, desc_num} + 17'd1) >= {1'b0, count};
        push(ST_OK, id_hold, off_hold, len, desc_num, is_final);
        if (is_final) ph = PH_DONE;
        else desc_num = desc_num + 1'b1;
        pos = '0;
        return;
      end
      pos = pos + 1'b1;
    endfunction

    // Matches one delivered result against the oldest expectation.
    function void compare_entry(logic [2:0] st, logic [WORD_W-1:0] id,
                                logic [WORD_W-1:0] off, logic [WORD_W-1:0] len,
                                logic [CNT_W-1:0] idx, logic [END_W-1:0] aend,
                                logic lst);
      entry_t e;
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d id=%h off=%h len=%h idx=%0d end=%h last=%b",
                   st, id, off, len, idx, aend, lst);
        return;
      end
      e = pending_entries.pop_front();
      if (e.st == ST_OK) entries_seen++;
      else errors_seen++;
      if (st !== e.st || id !== e.id || off !== e.off || len !== e.len ||
          idx !== e.idx || aend !== e.aend || lst !== e.last_flag) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t ns", $realtime);
          $display("  expected st=%0d id=%h off=%h len=%h idx=%0d end=%h last=%b",
                   e.st, e.id, e.off, e.len, e.idx, e.aend, e.last_flag);
          $display("  actual   st=%0d id=%h off=%h len=%h idx=%0d end=%h last=%b",
                   st, id, off, len, idx, aend, lst);
        end
      end
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [FSIZE_W-1:0]   cfg_file_size_i = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i     = '0;
  logic                 first_byte_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [2:0]           status_o;
  logic [WORD_W-1:0]    entry_id_o;
  logic [WORD_W-1:0]    entry_offset_o;
  logic [WORD_W-1:0]    entry_length_o;
  logic [CNT_W-1:0]     entry_index_o;
  logic [END_W-1:0]     span_end_o;
  logic                 last_o;

  wrapper_tracker sb = new();

  logic [FSIZE_W-1:0] cur_size     = '0;
  int unsigned        bytes_sent   = 0;
  int unsigned        burst_left   = 0;
  bit                 valid_low    = 1'b1;
  int unsigned        size_writes  = 0;
  int unsigned        mode_left    = 0;
  int unsigned        stall_left   = 0;
  int unsigned        ready_mode   = 0;

  applesingle_header_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_file_size_i (cfg_file_size_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .first_byte_i    (first_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entry_id_o      (entry_id_o),
    .entry_offset_o  (entry_offset_o),
    .entry_length_o  (entry_length_o),
    .entry_index_o   (entry_index_o),
    .span_end_o      (span_end_o),
    .last_o          (last_o)
  );

  // 50 MHz clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d results still outstanding", sb.pending());
    $display("FAIL");
    $finish;
  end

  // Result receiver: checks each delivered word and stalls in changing modes.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.compare_entry(status_o, entry_id_o, entry_offset_o, entry_length_o,
                       entry_index_o, span_end_o, last_o);
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  // Sends one byte; bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= first;
    valid_low     = 1'b0;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_byte(b, first);
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      valid_low   = 1'b1;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 30);
    end
  endtask

  // Drops the input valid once the last byte of a stretch has gone.
  task automatic end_input();
    if (!valid_low) begin
      in_valid_i <= 1'b0;
      valid_low   = 1'b1;
    end
  endtask

  // Writes file_size once the parser has drained and gone quiet.
  task automatic write_size(input logic [FSIZE_W-1:0] v);
    end_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_file_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_size(v);
    cur_size = v;
    size_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void push_word(ref logic [8:0] q[$], input logic [31:0] w);
    for (int k = 3; k >= 0; k--) q.push_back({1'b0, w[8*k +: 8]});
  endfunction

  // Random word with the extremes weighted in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random value in [0, limit], capped at the 32-bit range.
  function automatic logic [31:0] pick_fit(input logic [63:0] limit);
    logic [63:0] top;
    top = (limit > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : limit;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return top[31:0];
      default: return 32'(({$urandom, $urandom}) % (top + 64'd1));
    endcase
  endfunction

  // Builds one wrapper, mostly well formed, and sends it with optional noise.
  task automatic send_wrapper();
    logic [8:0]  seq[$];
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] doff;
    logic [31:0] dlen;
    logic [15:0] cnt;
    logic [33:0] tend;
    int unsigned keep;
    int unsigned ndesc;
    bit          magic_ok;
    bit          version_ok;

    case ($urandom_range(0, 19))
      0:       magic = $urandom;
      1:       magic = MAGIC_ONE ^ (32'h1 << $urandom_range(0, 31));
      default: magic = $urandom_range(0, 1) ? MAGIC_ONE : MAGIC_TWO;
    endcase
    case ($urandom_range(0, 19))
      0:       version = $urandom;
      1:       version = VERSION_TWO ^ (32'h1 << $urandom_range(0, 31));
      default: version = $urandom_range(0, 1) ? VERSION_ONE : VERSION_TWO;
    endcase
    case ($urandom_range(0, 19))
      0:       cnt = 16'h0000;
      1:       cnt = 16'hFFFF;
      2:       cnt = 16'($urandom);
      3, 4:    cnt = 16'($urandom_range(5, 20));
      default: cnt = 16'($urandom_range(1, 4));
    endcase
    magic_ok   = (magic == MAGIC_ONE) || (magic == MAGIC_TWO);
    version_ok = (version == VERSION_ONE) || (version == VERSION_TWO);
    tend       = HDR_BYTES + DESC_BYTES * cnt;

    push_word(seq, magic);
    seq[0][8] = 1'b1;
    push_word(seq, version);
    repeat (16) seq.push_back({1'b0, 8'($urandom)});
    seq.push_back({1'b0, cnt[15:8]});
    seq.push_back({1'b0, cnt[7:0]});

    // Only send as far as the parser will go for this header.
    if (!magic_ok) begin
      keep = 4;
    end else if (!version_ok) begin
      keep = 8;
    end else if (cnt == '0 || tend > cur_size) begin
      keep = 26;
    end else begin
      ndesc = (cnt > MAX_DESCS) ? MAX_DESCS : cnt;
      for (int d = 0; d < ndesc; d++) begin
        push_word(seq, pick_word());
        if ($urandom_range(0, 9) == 0) begin
          doff = $urandom;
          dlen = $urandom;
          if ({2'b00, doff} + {2'b00, dlen} <= cur_size) begin
            doff = 32'hFFFF_FFFF;
            dlen = 32'hFFFF_FFFF;
          end
        end else begin
          doff = pick_fit(64'(cur_size));
          dlen = pick_fit(64'(cur_size) - 64'(doff));
        end
        push_word(seq, doff);
        push_word(seq, dlen);
        if ({2'b00, doff} + {2'b00, dlen} > cur_size) break;
      end
      keep = seq.size();
    end
    if (cur_size < HDR_BYTES) keep = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, keep);

    for (int i = 0; i < keep; i++) send_byte(seq[i][7:0], seq[i][8]);

    // Trailing noise, now and then with a stray restart marker.
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 6))
        send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
  endtask

  // Main sequence: reset, directed cases, then random phases per file size.
  initial begin
    logic [FSIZE_W-1:0] sizes[12];
    int unsigned        phase_start;

    sizes[0]  = 40'd25;
    sizes[1]  = 40'd26;
    sizes[2]  = 40'd40;
    sizes[3]  = 40'd64;
    sizes[4]  = 40'd100;
    sizes[5]  = 40'd300;
    sizes[6]  = 40'd4096;
    sizes[7]  = 40'h00_0010_0000;
    sizes[8]  = {8'h00, $urandom};
    sizes[9]  = 40'h01_FFFF_FFFE;
    sizes[10] = 40'hFF_FFFF_FFFF;
    sizes[11] = {8'($urandom), $urandom};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unmarked start with no room, an ignored byte, then a marked restart.
    write_size(40'd0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3C, 1'b1);

    // Bad magic on its fourth byte, then bad version after a good magic.
    write_size(40'hFF_FFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h16, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(MAGIC_TWO[31:24], 1'b1);
    send_byte(MAGIC_TWO[23:16], 1'b0);
    send_byte(MAGIC_TWO[15:8], 1'b0);
    send_byte(MAGIC_TWO[7:0], 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);

    // Random wrappers under each file-size setting.
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_wrapper();
    end

    // Drain, then allow the pipeline time to show any stray result.
    end_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes under %0d file-size settings; %0d entries and %0d error words",
             bytes_sent, size_writes, sb.entries_seen, sb.errors_seen);
    $display("checked, %0d mismatches.", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
